>>> rtl/mmcs_pkg.sv
package mmcs_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [7:0] pixel_t;
  typedef logic [1:0] kind_t;

  // opcodes of an input item
  localparam opcode_t OP_CLEAR   = 2'd0;
  localparam opcode_t OP_MEASURE = 2'd1;
  localparam opcode_t OP_APPLY   = 2'd2;

  // kinds of a result item
  localparam kind_t KIND_STRETCHED = 2'd0;
  localparam kind_t KIND_FULL      = 2'd1;
  localparam kind_t KIND_UNIFORM   = 2'd2;

  localparam pixel_t PIXEL_MIN     = 8'd0;
  localparam pixel_t PIXEL_MAX     = 8'd255;
  localparam pixel_t UNIFORM_LEVEL = 8'd127;

endpackage

>>> rtl/mmcs_in_if.sv
interface mmcs_in_if;
  import mmcs_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  pixel_t  pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);

endinterface

>>> rtl/mmcs_out_if.sv
interface mmcs_out_if;
  import mmcs_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  kind_t  result_kind;

  modport source (output valid, output pixel_out, output result_kind, input ready);
  modport sink   (input valid, input pixel_out, input result_kind, output ready);

endinterface

>>> rtl/min_max_contrast_stretch_unit.sv
// Min/max contrast stretch for 8-bit grey levels, run in two passes over a frame.
// A clear transfer (opcode 0) resets the running minimum and maximum, measure
// transfers (opcode 1) fold one pixel into them and give no result, and apply
// transfers (opcode 2) give one result: (p - min) * 255 / (max - min), rounded to
// nearest with ties to even and saturated to 0..255. A full 0..255 range returns
// the pixel unchanged (kind 1); a uniform or unmeasured frame answers 127 (kind 2).
// Opcode 3 is accepted and ignored. Clear and measure complete on acceptance.
// An apply item that needs the division passes through acceptance, 8 restoring
// divider steps that retire one quotient bit per cycle, then a rounding step;
// apply items settled without division (saturated, full range, uniform) skip the divider.
// The unit holds one item at a time, and a finished result waits in the output
// register while the next item is accepted; only the final write of an apply
// result waits for that register to drain.
module min_max_contrast_stretch_unit (
  input  logic clk_i,
  input  logic rst_ni,
  mmcs_in_if.sink    in_i,
  mmcs_out_if.source out_o
);
  import mmcs_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // running statistics
  pixel_t low_q, low_d;
  pixel_t high_q, high_d;
  logic   any_q, any_d;

  logic [1:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;      // divider step counter
  pixel_t     rem_q, rem_d;      // partial remainder
  pixel_t     sh_q, sh_d;        // dividend low bits shift out, quotient bits shift in
  pixel_t     span_q, span_d;    // divisor max - min
  kind_t      kind_q, kind_d;
  logic       bypass_q, bypass_d; // result already final, no rounding

  logic   out_valid_q, out_valid_d;
  pixel_t out_pixel_q, out_pixel_d;
  kind_t  out_kind_q, out_kind_d;

  logic        in_xfer;
  logic        out_free;
  pixel_t      diff;
  logic [15:0] num;
  logic [8:0]  rem9;
  logic        ge;
  logic [8:0]  rem_sub;
  logic [8:0]  rem2;
  logic        round_up;
  pixel_t      result;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // numerator (p - min) * 255 as (d << 8) - d
  assign diff = in_i.pixel_in - low_q;
  assign num  = {diff, 8'd0} - {8'd0, diff};

  // one restoring step: bring down the next dividend bit
  assign rem9    = {rem_q, sh_q[7]};
  assign ge      = (rem9 >= {1'b0, span_q});
  assign rem_sub = rem9 - {1'b0, span_q};

  // ties to even; quotient stays at most 254 here, so +1 never overflows
  assign rem2     = {rem_q, 1'b0};
  assign round_up = (rem2 > {1'b0, span_q}) || ((rem2 == {1'b0, span_q}) && sh_q[0]);
  assign result   = bypass_q ? sh_q : (sh_q + {7'd0, round_up});

  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    any_d       = any_q;
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    span_d      = span_q;
    kind_d      = kind_q;
    bypass_d    = bypass_q;
    out_valid_d = out_valid_q;
    out_pixel_d = out_pixel_q;
    out_kind_d  = out_kind_q;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_i.opcode)
            OP_CLEAR: begin
              low_d  = PIXEL_MAX;
              high_d = PIXEL_MIN;
              any_d  = 1'b0;
            end
            OP_MEASURE: begin
              if (in_i.pixel_in < low_q) low_d = in_i.pixel_in;
              if (in_i.pixel_in > high_q) high_d = in_i.pixel_in;
              any_d = 1'b1;
            end
            OP_APPLY: begin
              bypass_d = 1'b1;
              kind_d   = KIND_STRETCHED;
              state_d  = ST_FINISH;
              span_d   = high_q - low_q;
              if (!any_q) begin
                sh_d   = UNIFORM_LEVEL;
                kind_d = KIND_UNIFORM;
              end else if (low_q == PIXEL_MIN && high_q == PIXEL_MAX) begin
                sh_d   = in_i.pixel_in;
                kind_d = KIND_FULL;
              end else if (high_q <= low_q) begin
                sh_d   = UNIFORM_LEVEL;
                kind_d = KIND_UNIFORM;
              end else if (in_i.pixel_in <= low_q) begin
                sh_d = PIXEL_MIN;
              end else if (in_i.pixel_in >= high_q) begin
                // at or above max the quotient reaches 255 exactly or more
                sh_d = PIXEL_MAX;
              end else begin
                // d < span, so the high byte of the numerator is below the divisor
                rem_d    = num[15:8];
                sh_d     = num[7:0];
                cnt_d    = 3'd0;
                bypass_d = 1'b0;
                state_d  = ST_DIV;
              end
            end
            default: begin
              // unused opcode, dropped
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d = ge ? rem_sub[7:0] : rem9[7:0];
        sh_d  = {sh_q[6:0], ge};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pixel_d = result;
          out_kind_d  = kind_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= PIXEL_MAX;
      high_q      <= PIXEL_MIN;
      any_q       <= 1'b0;
      state_q     <= ST_IDLE;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      low_q       <= low_d;
      high_q      <= high_d;
      any_q       <= any_d;
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    sh_q        <= sh_d;
    span_q      <= span_d;
    kind_q      <= kind_d;
    bypass_q    <= bypass_d;
    out_pixel_q <= out_pixel_d;
    out_kind_q  <= out_kind_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_out   = out_pixel_q;
  assign out_o.result_kind = out_kind_q;

endmodule

>>> rtl/mmcs_checker.sv
module mmcs_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input mmcs_pkg::opcode_t in_opcode_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input mmcs_pkg::pixel_t out_pixel_i,
  input mmcs_pkg::kind_t  out_kind_i
);
  import mmcs_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pixel_i) && $stable(out_kind_i))
    else $error("result payload changed while stalled");

  // an apply transfer occupies the unit for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_opcode_i == OP_APPLY |=> !in_ready_i)
    else $error("input taken while an apply item is in progress");

  // uniform answer is always mid grey
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_UNIFORM |-> out_pixel_i == UNIFORM_LEVEL)
    else $error("uniform result is not mid grey");

  // result kind code is one of the three defined ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i == KIND_STRETCHED || out_kind_i == KIND_FULL ||
                     out_kind_i == KIND_UNIFORM))
    else $error("undefined result kind");

endmodule

bind min_max_contrast_stretch_unit mmcs_checker u_mmcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.pixel_out),
  .out_kind_i  (out_o.result_kind)
);

>>> verif/tb_min_max_contrast_stretch_unit.sv
`timescale 1ns / 100ps

module tb_min_max_contrast_stretch_unit;
  import mmcs_pkg::*;

  // opcode 3 has no meaning, the unit takes it and drops it
  localparam opcode_t OP_UNUSED = 2'd3;

  localparam int TARGET_ITEMS   = 1550;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 12;    // a bit more than the slowest apply
  localparam int MAX_PRINTED    = 100;

  // one expected stretch result
  typedef struct packed {
    pixel_t level;
    kind_t  kind;
  } stretch_res_t;

  // one directed transfer; when typed is set the expected result is given here
  typedef struct packed {
    opcode_t op;
    pixel_t  px;
    logic    typed;
    pixel_t  level;
    kind_t   kind;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mmcs_in_if  in_bus ();
  mmcs_out_if out_bus ();

  min_max_contrast_stretch_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // predictor state: running minimum, maximum and the measured flag
  pixel_t low_level  = PIXEL_MAX;
  pixel_t high_level = PIXEL_MIN;
  logic   measured   = 1'b0;

  stretch_res_t stretched_q[$];  // results still owed by the unit, oldest first
  stretch_res_t head;
  int           mismatch_count = 0;
  int           items_sent     = 0;
  int           results_seen   = 0;
  int           burst_left     = 0;
  int           quiet_cycles   = 0;

  // directed part: reset state, unused opcode, full range, uniform frame,
  // saturation on both sides and both ways a rounding tie can go
  stim_row_t directed_rows [0:24] = '{
    '{OP_APPLY,   8'd200, 1'b1, UNIFORM_LEVEL, KIND_UNIFORM},    // nothing measured yet
    '{OP_UNUSED,  8'hAA,  1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'd0,   1'b1, UNIFORM_LEVEL, KIND_UNIFORM},    // unused opcode changed nothing
    '{OP_MEASURE, 8'd100, 1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'd50,  1'b1, UNIFORM_LEVEL, KIND_UNIFORM},    // single level seen
    '{OP_MEASURE, 8'd0,   1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_MEASURE, 8'd255, 1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'h55,  1'b1, 8'h55,         KIND_FULL},       // full range passes through
    '{OP_APPLY,   8'hAA,  1'b1, 8'hAA,         KIND_FULL},
    '{OP_CLEAR,   8'd0,   1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'd255, 1'b1, UNIFORM_LEVEL, KIND_UNIFORM},    // cleared
    '{OP_MEASURE, 8'd112, 1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_MEASURE, 8'd10,  1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'd0,   1'b1, PIXEL_MIN,     KIND_STRETCHED},  // below minimum
    '{OP_APPLY,   8'd255, 1'b1, PIXEL_MAX,     KIND_STRETCHED},  // above maximum
    '{OP_APPLY,   8'd10,  1'b1, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'd112, 1'b1, PIXEL_MAX,     KIND_STRETCHED},
    '{OP_APPLY,   8'd11,  1'b0, PIXEL_MIN,     KIND_STRETCHED},  // tie, even quotient stays
    '{OP_APPLY,   8'd61,  1'b0, PIXEL_MIN,     KIND_STRETCHED},  // tie, odd quotient rounds up
    '{OP_UNUSED,  8'h55,  1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_APPLY,   8'd200, 1'b1, PIXEL_MAX,     KIND_STRETCHED},
    '{OP_APPLY,   8'd100, 1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_CLEAR,   8'hFF,  1'b0, PIXEL_MIN,     KIND_STRETCHED},
    '{OP_MEASURE, 8'd255, 1'b0, PIXEL_MIN,     KIND_STRETCHED},  // minimum and maximum both 255
    '{OP_APPLY,   8'd0,   1'b1, UNIFORM_LEVEL, KIND_UNIFORM}
  };

  // clock, 12 ns period
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // updates the running statistics for one transfer and tells whether
  // it owes a result, and which
  function automatic bit predict_stretch(input opcode_t op, input pixel_t px,
                                         output stretch_res_t res);
    int span;
    int num;
    int quo;
    int rem;
    res = '0;
    if (op == OP_CLEAR) begin
      low_level  = PIXEL_MAX;
      high_level = PIXEL_MIN;
      measured   = 1'b0;
      return 1'b0;
    end
    if (op == OP_MEASURE) begin
      if (px < low_level)  low_level  = px;
      if (px > high_level) high_level = px;
      measured = 1'b1;
      return 1'b0;
    end
    if (op != OP_APPLY) return 1'b0;

    if (!measured) begin
      res = '{UNIFORM_LEVEL, KIND_UNIFORM};
    end else if (low_level == PIXEL_MIN && high_level == PIXEL_MAX) begin
      // full range check comes ahead of the uniform one
      res = '{px, KIND_FULL};
    end else if (high_level <= low_level) begin
      res = '{UNIFORM_LEVEL, KIND_UNIFORM};
    end else if (px <= low_level) begin
      res = '{PIXEL_MIN, KIND_STRETCHED};
    end else begin
      // exact quotient, round half to even, clip at the top level
      span = int'(high_level) - int'(low_level);
      num  = (int'(px) - int'(low_level)) * int'(PIXEL_MAX);
      quo  = num / span;
      rem  = num % span;
      if (2 * rem > span || (2 * rem == span && quo[0])) quo++;
      if (quo > int'(PIXEL_MAX)) quo = int'(PIXEL_MAX);
      res = '{pixel_t'(quo), KIND_STRETCHED};
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // offers one transfer; bursts of random length with idle gaps between them
  task automatic send_item(input opcode_t op, input pixel_t px,
                           input logic typed = 1'b0, input stretch_res_t typed_res = '0);
    stretch_res_t res;
    int           gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= op;
    in_bus.pixel_in <= px;
    do @(posedge clk_i); while (!in_bus.ready);
    // transfer taken at this edge
    if (predict_stretch(op, px, res)) stretched_q.push_back(typed ? typed_res : res);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stop offering until every owed result has come out
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (stretched_q.size() != 0);
    burst_left = 0;
  endtask

  // one frame: mostly clear, measure a few pixels, apply a few; the shape picks
  // full range, uniform, narrow span or a random span, with stray unused
  // opcodes, missing clears and empty measure passes mixed in
  task automatic run_frame();
    int shape;
    int lo;
    int hi;
    int n_meas;
    int n_apply;
    int px;
    shape = $urandom_range(0, 9);
    lo    = $urandom_range(0, 255);
    hi    = $urandom_range(lo, 255);
    case (shape)
      0: begin
        lo = 0;
        hi = 255;
      end
      1: hi = lo;
      2: hi = (lo + 3 > 255) ? 255 : lo + 3;
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0) send_item(OP_CLEAR, pixel_t'($urandom_range(0, 255)));
    n_meas = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
    for (int i = 0; i < n_meas; i++) begin
      if ($urandom_range(0, 24) == 0) send_item(OP_UNUSED, pixel_t'($urandom_range(0, 255)));
      if (i == 0)      px = lo;
      else if (i == 1) px = hi;
      else             px = $urandom_range(lo, hi);
      send_item(OP_MEASURE, pixel_t'(px));
    end
    n_apply = $urandom_range(1, 10);
    for (int i = 0; i < n_apply; i++) begin
      if ($urandom_range(0, 24) == 0) send_item(OP_UNUSED, pixel_t'($urandom_range(0, 255)));
      px = $urandom_range(0, 1) ? $urandom_range(lo, hi) : $urandom_range(0, 255);
      send_item(OP_APPLY, pixel_t'(px));
    end
  endtask

  // stimulus: reset, directed table, random frames, drain, verdict
  initial begin
    rst_ni          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.opcode   <= OP_CLEAR;
    in_bus.pixel_in <= PIXEL_MIN;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].px, directed_rows[i].typed,
                '{directed_rows[i].level, directed_rows[i].kind});
    end
    // sender waits for the unit to run dry at least once
    settle();

    while (items_sent < TARGET_ITEMS) begin
      run_frame();
      if ($urandom_range(0, 15) == 0) settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && stretched_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: spans of always ready, coin-flip ready and sparse ready, with
  // two long hold-offs so the unit backs up and stalls its input side
  initial begin
    int mode;
    int span_len;
    int holds_done;
    holds_done = 0;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ((holds_done == 0 && results_seen >= 40) ||
          (holds_done == 1 && results_seen >= 500)) begin
        holds_done++;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode     = $urandom_range(0, 2);
      span_len = $urandom_range(1, 60);
      repeat (span_len) begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // result checker: every output transfer against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (stretched_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel %0d kind %0d",
                                  out_bus.pixel_out, out_bus.result_kind));
      end else begin
        head = stretched_q.pop_front();
        if (out_bus.pixel_out !== head.level)
          report_mismatch($sformatf("pixel_out %0d, wanted %0d",
                                    out_bus.pixel_out, head.level));
        if (out_bus.result_kind !== head.kind)
          report_mismatch($sformatf("result_kind %0d, wanted %0d",
                                    out_bus.result_kind, head.kind));
      end
    end
  end

  // watchdog: too long without any transfer means the unit is stuck
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
